FILE: hdl/spmv_pkg.sv
`default_nettype none
package spmv_pkg;
    localparam int MAX_N = 16;
    localparam int IDX_W = $clog2(MAX_N);
    localparam int CNT_W = $clog2(MAX_N + 1);
    localparam int ACC_W = 32 + 32 + IDX_W + 1;

    typedef enum logic [1:0] {
        OP_FILL = 2'd0,
        OP_WR_MAT = 2'd1,
        OP_WR_VEC = 2'd2,
        OP_MULT = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] row;
        logic [3:0] col;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [3:0] out_row;
        logic signed [47:0] out_value;
        logic last;
    } rsp_t;

    // Per-cell control broadcast from the sequencer
    typedef struct packed {
        logic fill;
        logic wr_mat;
        logic [IDX_W-1:0] wr_r;
        logic [IDX_W-1:0] wr_c;
        logic signed [31:0] wr_val;
        logic shift;
    } cell_ctl_t;

    function automatic logic signed [47:0] sat48(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-17:0] s;
        s = acc[ACC_W-1:16];
        if (s > $signed({{(ACC_W-63){1'b0}}, 47'h7FFF_FFFF_FFFF}))
            return 48'sh7FFF_FFFF_FFFF;
        else if (s < $signed({{(ACC_W-63){1'b1}}, 47'h0}))
            return 48'sh8000_0000_0000;
        else
            return s[47:0];
    endfunction
endpackage
`default_nettype wire

FILE: hdl/spmv_if.sv
`default_nettype none
interface spmv_req_if;
    logic valid;
    logic ready;
    spmv_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spmv_rsp_if;
    logic valid;
    logic ready;
    spmv_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spmv_cfg_if;
    logic valid;
    logic ready;
    logic [4:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/spmv_cell.sv
`default_nettype none
// One matrix row (full, symmetric entries mirrored) and a circulating vector slot.
module spmv_cell (
    input  wire logic                          clk,
    input  wire logic [spmv_pkg::IDX_W-1:0]    my_row,
    input  wire spmv_pkg::cell_ctl_t           ctl,
    input  wire logic signed [31:0]            vec_in,
    input  wire logic [spmv_pkg::IDX_W-1:0]    col_sel,
    input  wire logic signed [31:0]            vec_load,
    input  wire logic                          vec_load_en,
    output logic signed [31:0]                 vec_out,
    output logic signed [31:0]                 mat_elem
);
    logic signed [31:0] row_reg [spmv_pkg::MAX_N];
    logic signed [31:0] vec_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < spmv_pkg::MAX_N; j++)
        begin
            if (ctl.fill)
                row_reg[j] <= ctl.wr_val;
            else if (ctl.wr_mat &&
                     ((ctl.wr_r == my_row && ctl.wr_c == spmv_pkg::IDX_W'(j)) ||
                      (ctl.wr_c == my_row && ctl.wr_r == spmv_pkg::IDX_W'(j))))
                row_reg[j] <= ctl.wr_val;
        end
        if (vec_load_en)
            vec_reg <= vec_load;
        else if (ctl.shift)
            vec_reg <= vec_in;
    end

    assign vec_out  = vec_reg;
    assign mat_elem = row_reg[col_sel];
endmodule
`default_nettype wire

FILE: hdl/spmv_mac.sv
`default_nettype none
// Multiply registered, then accumulate.
module spmv_mac (
    input  wire logic                              clk,
    input  wire logic                              clr,
    input  wire logic                              en,
    input  wire logic signed [31:0]                a,
    input  wire logic signed [31:0]                b,
    output logic signed [spmv_pkg::ACC_W-1:0]      acc
);
    logic signed [63:0] prod_reg;
    logic signed [spmv_pkg::ACC_W-1:0] acc_reg;
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        if (clr)
            acc_reg <= '0;
        else if (en)
            acc_reg <= acc_reg + spmv_pkg::ACC_W'(prod_reg);
    end
    assign acc = acc_reg;
endmodule
`default_nettype wire

FILE: hdl/symmetric_packed_matvec.sv
`default_nettype none
// channel  | dir | payload
// req      | in  | opcode, row, col, value
// rsp      | out | out_row, out_value, last
// cfg      | in  | size_in_use
// A load is written when it is accepted. A multiply takes no new request until its last
// row is out: each row walks n columns through one MAC, then states S_DRAIN1, S_DRAIN2
// and S_OUT; the vector circulates along the cell chain.
// Results leave through a register; a stalled result holds the walk.
// Reset clears control and sets size_in_use to 16; stores are undefined until written.
module symmetric_packed_matvec (
    input wire logic clk,
    input wire logic rst_n,
    spmv_req_if.sink   req,
    spmv_rsp_if.source rsp,
    spmv_cfg_if.sink   cfg
);
    localparam int N = spmv_pkg::MAX_N;
    localparam int IW = spmv_pkg::IDX_W;
    localparam int CW = spmv_pkg::CNT_W;

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN1, S_DRAIN2, S_OUT} state_t;
    state_t state_reg;
    logic [4:0] size_reg;
    logic [CW-1:0] n_reg, col_reg, row_reg;
    logic rsp_valid_reg;
    spmv_pkg::rsp_t rsp_reg;

    logic [CW-1:0] n_eff;
    assign n_eff = (size_reg > 5'(N)) ? CW'(N) : CW'(size_reg);

    logic acc_go;
    assign acc_go = (state_reg == S_IDLE) && req.valid && !rsp_valid_reg;
    assign req.ready = acc_go;
    assign cfg.ready = 1'b1;

    spmv_pkg::cell_ctl_t ctl;
    always_comb
    begin
        ctl.fill   = acc_go && req.data.opcode == spmv_pkg::OP_FILL;
        ctl.wr_mat = acc_go && req.data.opcode == spmv_pkg::OP_WR_MAT &&
                     CW'(req.data.row) < n_eff && CW'(req.data.col) < n_eff;
        ctl.wr_r   = IW'(req.data.row);
        ctl.wr_c   = IW'(req.data.col);
        ctl.wr_val = req.data.value;
        ctl.shift  = (state_reg == S_RUN);
    end

    // Vector rotates one cell a cycle in S_RUN through the active n; cell 0 feeds MAC.
    // Cells beyond the active n hold their vector element.
    logic signed [31:0] vec_o [N];
    logic signed [31:0] mat_o [N];
    logic vec_wr;
    assign vec_wr = acc_go && req.data.opcode == spmv_pkg::OP_WR_VEC &&
                    CW'(req.data.row) < n_eff;
    logic [IW-1:0] last_cell;
    assign last_cell = IW'(n_reg - 1'b1);

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        logic signed [31:0] vin;
        logic [IW-1:0] vsel;
        assign vin = (IW'(g) == last_cell) ? vec_o[0] :
                     (IW'(g) > last_cell) ? vec_o[g] : vec_o[(g + 1) % N];
        // during run, element for cell 0's vector index is column col_reg
        assign vsel = IW'(col_reg);
        spmv_cell u_cell (
            .clk(clk), .my_row(IW'(g)), .ctl(ctl), .vec_in(vin),
            .col_sel(vsel), .vec_load(req.data.value),
            .vec_load_en(vec_wr && IW'(req.data.row) == IW'(g)),
            .vec_out(vec_o[g]), .mat_elem(mat_o[g])
        );
    end

    logic signed [spmv_pkg::ACC_W-1:0] acc;
    logic mac_en_reg;
    logic mac_clr;
    assign mac_clr = acc_go || (state_reg == S_OUT && !rsp_valid_reg);
    spmv_mac u_mac (
        .clk(clk), .clr(mac_clr), .en(mac_en_reg),
        .a(mat_o[IW'(row_reg)]), .b(vec_o[0]), .acc(acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg <= 5'd16;
            n_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg <= '0;
            mac_en_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                size_reg <= cfg.data;
            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            mac_en_reg <= (state_reg == S_RUN);
            case (state_reg)
                S_IDLE:
                begin
                    if (acc_go && req.data.opcode == spmv_pkg::OP_MULT && n_eff != '0)
                    begin
                        n_reg <= n_eff;
                        row_reg <= '0;
                        col_reg <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (col_reg == n_reg - 1'b1)
                        state_reg <= S_DRAIN1;
                    else
                        col_reg <= col_reg + 1'b1;
                end
                S_DRAIN1: state_reg <= S_DRAIN2;
                S_DRAIN2: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (!rsp_valid_reg)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_reg.out_row <= 4'(row_reg);
                        rsp_reg.out_value <= spmv_pkg::sat48(acc);
                        rsp_reg.last <= (row_reg == n_reg - 1'b1);
                        col_reg <= '0;
                        if (row_reg == n_reg - 1'b1)
                            state_reg <= S_IDLE;
                        else
                        begin
                            row_reg <= row_reg + 1'b1;
                            state_reg <= S_RUN;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data = rsp_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> col_reg < n_reg) else $error("column overrun");
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> row_reg < n_reg) else $error("row overrun");
`endif
endmodule
`default_nettype wire

FILE: test/symmetric_packed_matvec_tb.sv
`timescale 1ns / 1ps
module symmetric_packed_matvec_tb;
    typedef struct {
        spmv_pkg::req_t     q;
        bit                 fixed;
        logic signed [47:0] known;
    } stim_row_t;

    logic clk;
    logic rst_n;

    spmv_req_if req ();
    spmv_rsp_if rsp ();
    spmv_cfg_if cfg ();

    symmetric_packed_matvec u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    logic signed [31:0] mat_cells [spmv_pkg::MAX_N*(spmv_pkg::MAX_N+1)/2];
    logic signed [31:0] vec_cells [spmv_pkg::MAX_N];
    logic [4:0]         size_reg;
    spmv_pkg::rsp_t     pending_rows [$];
    stim_row_t          dir_tab [$];

    int  errors = 0;
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  long_hold = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int cell_addr(input int r, input int c);
        int hi;
        int lo;
        hi = (r > c) ? r : c;
        lo = (r > c) ? c : r;
        return hi * (hi + 1) / 2 + lo;
    endfunction

    function automatic logic signed [47:0] row_product(input int r, input int n);
        logic signed [69:0] acc;
        logic signed [69:0] ea;
        logic signed [69:0] eb;
        logic signed [69:0] s;
        acc = '0;
        for (int c = 0; c < n; c++)
        begin
            ea = mat_cells[cell_addr(r, c)];
            eb = vec_cells[c];
            acc += ea * eb;
        end
        s = acc >>> 16;
        if (s > 70'sh7FFF_FFFF_FFFF)
            return 48'sh7FFF_FFFF_FFFF;
        else if (s < -70'sh8000_0000_0000)
            return 48'sh8000_0000_0000;
        else
            return s[47:0];
    endfunction

    // Update the mirror state and queue the rows a multiply produces
    task automatic apply_request(input spmv_pkg::req_t q, input bit fixed,
                                 input logic signed [47:0] known);
        int             n;
        spmv_pkg::rsp_t e;
        n = (size_reg > spmv_pkg::MAX_N) ? spmv_pkg::MAX_N : size_reg;
        case (spmv_pkg::op_t'(q.opcode))
            spmv_pkg::OP_FILL:
                foreach (mat_cells[i])
                    mat_cells[i] = q.value;
            spmv_pkg::OP_WR_MAT:
                if (q.row < n && q.col < n)
                    mat_cells[cell_addr(q.row, q.col)] = q.value;
            spmv_pkg::OP_WR_VEC:
                if (q.row < n)
                    vec_cells[q.row] = q.value;
            spmv_pkg::OP_MULT:
                for (int i = 0; i < n; i++)
                begin
                    e.out_row = i[3:0];
                    e.out_value = fixed ? known : row_product(i, n);
                    e.last = (i + 1 == n);
                    pending_rows.push_back(e);
                end
            default: ;
        endcase
    endtask

    task automatic send_request(input spmv_pkg::req_t q, input bit fixed,
                                input logic signed [47:0] known);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data <= q;
        do
            @(posedge clk);
        while (!req.ready);
        apply_request(q, fixed, known);
        @(negedge clk);
    endtask

    // Drain, let trailing loads settle, then change the size
    task automatic set_size(input logic [4:0] sz);
        req.valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= sz;
        do
            @(posedge clk);
        while (!cfg.ready);
        size_reg = sz;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(32'h3_FFFF)) - 32'sh2_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic spmv_pkg::req_t random_request();
        spmv_pkg::req_t q;
        int             k;
        k = $urandom_range(99);
        q.row = 4'($urandom_range(15));
        q.col = 4'($urandom_range(15));
        q.value = pick_value();
        if (k < 6)
            q.opcode = spmv_pkg::OP_FILL;
        else if (k < 48)
            q.opcode = spmv_pkg::OP_WR_MAT;
        else if (k < 84)
            q.opcode = spmv_pkg::OP_WR_VEC;
        else
            q.opcode = spmv_pkg::OP_MULT;
        return q;
    endfunction

    function automatic stim_row_t mk(input spmv_pkg::op_t op, input int r, input int c,
                                     input logic signed [31:0] v, input bit fixed,
                                     input logic signed [47:0] known);
        stim_row_t t;
        t.q.opcode = op;
        t.q.row = r[3:0];
        t.q.col = c[3:0];
        t.q.value = v;
        t.fixed = fixed;
        t.known = known;
        return t;
    endfunction

    // Receiver: random ready, with one long hold-off to back up the block
    initial
    begin
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp.ready <= 1'b0;
                repeat (800) @(negedge clk);
                long_hold = 0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        spmv_pkg::rsp_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_rows.size() == 0)
            begin
                $display("%0t: unexpected result row=%0d value=%0d last=%0b", $time,
                         rsp.data.out_row, rsp.data.out_value, rsp.data.last);
                errors++;
            end
            else
            begin
                e = pending_rows.pop_front();
                if (rsp.data.out_row !== e.out_row)
                begin
                    $display("%0t: out_row expected %0d actual %0d", $time,
                             e.out_row, rsp.data.out_row);
                    errors++;
                end
                if (rsp.data.out_value !== e.out_value)
                begin
                    $display("%0t: out_value expected %0d actual %0d", $time,
                             e.out_value, rsp.data.out_value);
                    errors++;
                end
                if (rsp.data.last !== e.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             e.last, rsp.data.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic [4:0] sizes [7];
        int         waited;
        stim_row_t  t;
        sizes = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd16};
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        size_reg = 5'd16;
        foreach (mat_cells[i])
            mat_cells[i] = '0;
        foreach (vec_cells[i])
            vec_cells[i] = '0;

        // Every store entry gets written before the first multiply
        dir_tab.push_back(mk(spmv_pkg::OP_FILL, 9, 4, 32'sh7FFF_FFFF, 0, 0));
        for (int i = 0; i < spmv_pkg::MAX_N; i++)
            dir_tab.push_back(mk(spmv_pkg::OP_WR_VEC, i, 15 - i, 32'sh7FFF_FFFF, 0, 0));
        dir_tab.push_back(mk(spmv_pkg::OP_MULT, 0, 0, 0, 1, 48'sh7FFF_FFFF_FFFF));
        dir_tab.push_back(mk(spmv_pkg::OP_FILL, 0, 0, 32'sh8000_0000, 0, 0));
        dir_tab.push_back(mk(spmv_pkg::OP_MULT, 15, 15, -1, 1, 48'sh8000_0000_0000));
        dir_tab.push_back(mk(spmv_pkg::OP_WR_MAT, 15, 0, 32'sh0001_0000, 0, 0));
        dir_tab.push_back(mk(spmv_pkg::OP_WR_MAT, 3, 9, 32'shFFFF_0000, 0, 0));
        dir_tab.push_back(mk(spmv_pkg::OP_WR_VEC, 0, 7, 32'sh8000_0000, 0, 0));
        dir_tab.push_back(mk(spmv_pkg::OP_MULT, 5, 10, 32'sh1234_5678, 0, 0));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle = 12;
        recv_idle = 72;
        foreach (dir_tab[i])
        begin
            t = dir_tab[i];
            send_request(t.q, t.fixed, t.known);
        end

        foreach (sizes[p])
        begin
            set_size(sizes[p]);
            if (p == 3)
            begin
                send_idle = 72;
                recv_idle = 12;
            end
            else if (p == 5)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (p == 0)
                long_hold = 1;
            for (int k = 0; k < 55; k++)
                send_request(random_request(), 0, 0);
        end
        req.valid <= 1'b0;

        while (pending_rows.size() != 0)
            @(negedge clk);
        waited = 0;
        while (waited < 300)
        begin
            @(negedge clk);
            waited++;
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: sim.f
hdl/spmv_pkg.sv
hdl/spmv_if.sv
hdl/spmv_cell.sv
hdl/spmv_mac.sv
hdl/symmetric_packed_matvec.sv
test/symmetric_packed_matvec_tb.sv
